FILE: design/slr_pkg.sv
// Shared types and constants for the windowed STA/LTA ratio block.
package slr_pkg;

  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned RATIO_BITS     = 29;
  localparam int unsigned SHORT_LEN_BITS = 11;
  localparam int unsigned LONG_LEN_BITS  = 13;
  localparam int unsigned ADDR_BITS      = 3;
  localparam int unsigned DATA_BITS      = 32;

  localparam logic [SHORT_LEN_BITS-1:0] SHORT_LEN_RESET = 11'd1024;
  localparam logic [LONG_LEN_BITS-1:0]  LONG_LEN_RESET  = 13'd4096;

  localparam logic [0:0] REG_SHORT_LEN = 1'b0;
  localparam logic [0:0] REG_LONG_LEN  = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_block;
  } in_beat_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] ratio;
    logic                  zero_energy;
    logic                  block_done;
  } out_beat_t;

  typedef struct packed {
    logic clear;
    logic rd;
    logic upd;
  } win_ctrl_t;

endpackage

FILE: design/slr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/slr_window.sv
// One sliding window: ring of magnitudes, running sum, fill count and position.
module slr_window #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned CFG_W = 11,
  localparam int unsigned FW = $clog2(DEPTH + 1),
  localparam int unsigned SW = slr_pkg::SAMPLE_BITS - 1 + FW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  slr_pkg::win_ctrl_t             ctrl_i,
  input  logic [CFG_W-1:0]               cfg_len_i,
  input  logic [slr_pkg::SAMPLE_BITS-1:0] mag_i,
  output logic [SW-1:0]                  sum_o,
  output logic [FW-1:0]                  fill_o
);
  import slr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SW-1:0]          sum_q, sum_d;
  logic [FW-1:0]          fill_q, fill_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [FW-1:0]          len;
  logic [AW-1:0]          pos_eff;
  logic [FW-1:0]          pos_inc;
  logic [SAMPLE_BITS-1:0] old_mag;

  always_comb begin
    if (cfg_len_i == '0) begin
      len = FW'(1);
    end else if (32'(cfg_len_i) > DEPTH) begin
      len = FW'(DEPTH);
    end else begin
      len = FW'(cfg_len_i);
    end
  end

  assign pos_eff = (FW'(pos_q) >= len) ? '0 : pos_q;
  assign pos_inc = FW'(pos_eff) + FW'(1);

  slr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.upd),
    .waddr_i (pos_eff),
    .wdata_i (mag_i),
    .re_i    (ctrl_i.rd),
    .raddr_i (pos_eff),
    .rdata_o (old_mag)
  );

  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    pos_d  = pos_q;
    if (ctrl_i.clear) begin
      sum_d  = '0;
      fill_d = '0;
      pos_d  = '0;
    end else if (ctrl_i.upd) begin
      if (fill_q < len) begin
        sum_d  = sum_q + SW'(mag_i);
        fill_d = fill_q + FW'(1);
      end else begin
        sum_d = sum_q - SW'(old_mag) + SW'(mag_i);
      end
      pos_d = (pos_inc >= len) ? '0 : AW'(pos_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      pos_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      pos_q  <= pos_d;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

FILE: design/slr_divider.sv
// Restoring divider, one quotient bit per cycle, with saturation check.
module slr_divider #(
  parameter int unsigned NW        = 47,
  parameter int unsigned DW        = 47,
  parameter int unsigned LONG_DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NW-1:0]                 num_i,
  input  logic [DW-1:0]                 den_i,
  output logic                          done_o,
  output logic [slr_pkg::RATIO_BITS-1:0] ratio_o
);
  import slr_pkg::*;

  localparam int unsigned LB   = $clog2(LONG_DEPTH);
  localparam int unsigned SHW  = LB + FRAC_BITS;
  localparam int unsigned RW   = DW + 1;
  localparam int unsigned PW   = DW + LB + 1;
  localparam int unsigned CMPW = (NW > PW) ? NW : PW;
  localparam int unsigned CW   = $clog2(SHW + 1);
  localparam logic [63:0] SAT_VAL = 64'(LONG_DEPTH) << FRAC_BITS;

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_RUN   = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [NW-1:0]         num_q, num_d;
  logic [DW-1:0]         den_q, den_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [SHW-1:0]        dsh_q, dsh_d;
  logic [SHW-1:0]        quo_q, quo_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  sat_q, sat_d;
  logic                  done_q, done_d;
  logic [CMPW-1:0]       limit;
  logic [NW+FRAC_BITS-1:0] num_ext;
  logic [RW-1:0]         trial;

  assign limit   = CMPW'(PW'(den_q) * PW'(LONG_DEPTH));
  assign num_ext = {num_q, {FRAC_BITS{1'b0}}};
  assign trial   = {rem_q[RW-2:0], dsh_q[SHW-1]};

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          num_d   = num_i;
          den_d   = den_i;
          sat_d   = 1'b0;
          state_d = D_CHECK;
        end
      end
      D_CHECK: begin
        if (CMPW'(num_q) >= limit) begin
          sat_d   = 1'b1;
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          rem_d   = RW'(num_q >> LB);
          dsh_d   = num_ext[SHW-1:0];
          quo_d   = '0;
          cnt_d   = '0;
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        if (trial >= RW'(den_q)) begin
          rem_d = trial - RW'(den_q);
          quo_d = {quo_q[SHW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[SHW-2:0], 1'b0};
        end
        dsh_d = dsh_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(SHW - 1)) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o  = done_q;
  assign ratio_o = sat_q ? SAT_VAL[RATIO_BITS-1:0] : RATIO_BITS'(quo_q);

endmodule

FILE: design/sta_lta_windowed_ratio.sv
// Top level of the windowed STA/LTA ratio block.
// An accepted beat passes the update, product, start and check stages, 28 divider steps
// and the output stage; a saturated ratio skips the divider steps, zero long energy skips check and steps.
// A new beat is taken only once the last result is loaded into the output register;
// a stalled result beat holds off the next one.
// Reset: sums, fill counts and positions clear; lengths return to 1024 and 4096.
// Ring memories are not cleared; an entry's old value is used only after it was written.
module sta_lta_windowed_ratio #(
  parameter int unsigned SHORT_DEPTH = 1024,
  parameter int unsigned LONG_DEPTH  = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  slr_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output slr_pkg::out_beat_t                out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slr_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [slr_pkg::DATA_BITS-1:0]     pwdata,
  output logic [slr_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);
  import slr_pkg::*;

  localparam int unsigned SFW = $clog2(SHORT_DEPTH + 1);
  localparam int unsigned LFW = $clog2(LONG_DEPTH + 1);
  localparam int unsigned SSW = SAMPLE_BITS - 1 + SFW;
  localparam int unsigned LSW = SAMPLE_BITS - 1 + LFW;
  localparam int unsigned NW  = SSW + LFW;
  localparam int unsigned DW  = LSW + SFW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [SHORT_LEN_BITS-1:0] slen_q;
  logic [LONG_LEN_BITS-1:0]  llen_q;
  logic                     cfg_wr;
  logic                     in_acc;
  logic [SAMPLE_BITS-1:0]   mag, mag_q;
  logic                     eob_q;
  logic                     zero_q;
  logic [NW-1:0]            num_q;
  logic [DW-1:0]            den_q;
  logic [RATIO_BITS-1:0]    ratio_q;
  logic                     out_valid_q;
  out_beat_t                out_q;
  logic                     out_load;
  win_ctrl_t                win_ctrl;
  logic [SSW-1:0]           s_sum;
  logic [SFW-1:0]           s_fill;
  logic [LSW-1:0]           l_sum;
  logic [LFW-1:0]           l_fill;
  logic                     div_start;
  logic                     div_done;
  logic [RATIO_BITS-1:0]    div_ratio;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2:2])
      REG_SHORT_LEN: prdata = DATA_BITS'(slen_q);
      default:       prdata = DATA_BITS'(llen_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slen_q <= SHORT_LEN_RESET;
      llen_q <= LONG_LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2:2])
        REG_SHORT_LEN: slen_q <= pwdata[SHORT_LEN_BITS-1:0];
        default:       llen_q <= pwdata[LONG_LEN_BITS-1:0];
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mag = in_data_i.sample[SAMPLE_BITS-1] ? (~in_data_i.sample + SAMPLE_BITS'(1))
                                                : in_data_i.sample;

  assign win_ctrl.clear = cfg_wr;
  assign win_ctrl.rd    = in_acc;
  assign win_ctrl.upd   = (state_q == S_UPD);

  slr_window #(
    .DEPTH (SHORT_DEPTH),
    .CFG_W (SHORT_LEN_BITS)
  ) u_short (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .cfg_len_i (slen_q),
    .mag_i     (mag_q),
    .sum_o     (s_sum),
    .fill_o    (s_fill)
  );

  slr_window #(
    .DEPTH (LONG_DEPTH),
    .CFG_W (LONG_LEN_BITS)
  ) u_long (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .cfg_len_i (llen_q),
    .mag_i     (mag_q),
    .sum_o     (l_sum),
    .fill_o    (l_fill)
  );

  assign div_start = (state_q == S_START) && !zero_q;

  slr_divider #(
    .NW         (NW),
    .DW         (DW),
    .LONG_DEPTH (LONG_DEPTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .ratio_o (div_ratio)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_UPD;
        end
      end
      S_UPD:   state_d = S_MUL;
      S_MUL:   state_d = S_START;
      S_START: state_d = zero_q ? S_OUT : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q <= mag;
      eob_q <= in_data_i.end_of_block;
    end
    if (state_q == S_MUL) begin
      num_q  <= NW'(s_sum) * NW'(l_fill);
      den_q  <= DW'(l_sum) * DW'(s_fill);
      zero_q <= (l_sum == '0);
    end
    if (state_q == S_START) begin
      ratio_q <= '0;
    end else if ((state_q == S_DIV) && div_done) begin
      ratio_q <= div_ratio;
    end
    if (out_load) begin
      out_q.ratio       <= ratio_q;
      out_q.zero_energy <= zero_q;
      out_q.block_done  <= eob_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_accept_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_UPD)
    else $error("accepted beat did not start a window update");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result beat appeared outside the output stage");

  a_zero_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_energy |-> out_data_o.ratio == '0)
    else $error("zero energy beat carries a nonzero ratio");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide stage");
`endif

endmodule
